>>> rtl/skts_pkg.sv
// Shared types and constants for the sorted key table search block.
// No dependencies; every other file in rtl/ but skts_ram refers to this package by scoped name.
package skts_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 16;
    localparam int PAY_W        = 32;
    localparam int IDX_W        = 6;

    localparam logic ACTION_INSERT = 1'b0;
    localparam logic ACTION_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_ADDR,
        S_INS_CMP,
        S_LK_ADDR,
        S_LK_CMP,
        S_DONE
    } state_t;

    // One table record as stored in the RAM
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

    localparam int ENTRY_W = KEY_W + PAY_W;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] index;
        logic [PAY_W-1:0] found_payload;
    } res_t;

endpackage

>>> rtl/skts_req_if.sv
// Request channel: valid/ready handshake carrying one action, key and payload per beat.
// Depends on skts_pkg for field widths.
interface skts_req_if;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [skts_pkg::KEY_W-1:0] key;
    logic [skts_pkg::PAY_W-1:0] payload;

    modport source (output valid, output action, output key, output payload, input ready);
    modport sink   (input valid, input action, input key, input payload, output ready);
endinterface

>>> rtl/skts_rsp_if.sv
// Response channel: valid/ready handshake carrying status, index and payload per beat.
// Depends on skts_pkg for field widths.
interface skts_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [skts_pkg::IDX_W-1:0]  index;
    logic [skts_pkg::PAY_W-1:0]  found_payload;

    modport source (output valid, output status, output index, output found_payload,
                    input ready);
    modport sink   (input valid, input status, input index, input found_payload,
                    output ready);
endinterface

>>> rtl/sorted_key_table_search_top.sv
// Top level of the sorted key table search block: controller, table RAM, output register.
// Depends on skts_pkg, skts_req_if, skts_rsp_if, skts_ram and skts_ctrl.
//
// Usage:
//   req carries one beat per item: action (0 insert, 1 lookup), key, payload.
//   rsp returns exactly one beat per item: status, index, found_payload.
//   Items are handled one at a time; req.ready is high only while the controller is idle.
// Steps from accept to result in the output register:
//   insert:  the shift loop moves each record above the new one up a slot, one record
//            per cycle, then writes the new record; into an empty table it goes straight to slot 0.
//   full:    no table access; the result is ST_FULL.
//   lookup:  binary search, at most floor(log2(count)) + 1 probes, ending on a hit
//            or when the search span is empty (a miss);
//            each probe waits for the registered RAM read.
// Reset (rst_n, asynchronous, active low) empties the table at once; RAM contents are
//   left as they are and only entries below the count are ever read.
// Stall: a result waits in the output register; the next item may be accepted and
//   worked on meanwhile, and its result is held in the controller until the slot frees.
module sorted_key_table_search_top #(
    parameter int CAPACITY = skts_pkg::CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    skts_req_if.sink   req,
    skts_rsp_if.source rsp
);

    localparam int AW = $clog2(CAPACITY);

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    skts_pkg::entry_t  ram_wdata;
    skts_pkg::entry_t  ram_rdata;
    logic              res_valid;
    logic              res_ready;
    skts_pkg::res_t    res;
    logic              out_valid_reg;
    skts_pkg::res_t    out_reg;

    skts_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_ready   (req.ready),
        .req_action  (req.action),
        .req_key     (req.key),
        .req_payload (req.payload),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    skts_ram #(
        .WIDTH (skts_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output slot frees when empty or when its beat is taken this cycle
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_reg.status;
    assign rsp.index         = out_reg.index;
    assign rsp.found_payload = out_reg.found_payload;

endmodule

>>> rtl/skts_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module skts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/skts_ctrl.sv
// Sequencer for the sorted table: insertion shift from the top and binary search lookup.
// Depends on skts_pkg; drives the table RAM in skts_ram and hands results to the top level.
module skts_ctrl #(
    parameter int CAPACITY = skts_pkg::CAPACITY_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request side
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic                            req_action,
    input  logic [skts_pkg::KEY_W-1:0]      req_key,
    input  logic [skts_pkg::PAY_W-1:0]      req_payload,
    // table RAM
    output logic                            ram_we,
    output logic [$clog2(CAPACITY)-1:0]     ram_waddr,
    output skts_pkg::entry_t                ram_wdata,
    output logic [$clog2(CAPACITY)-1:0]     ram_raddr,
    input  skts_pkg::entry_t                ram_rdata,
    // result side
    output logic                            res_valid,
    input  logic                            res_ready,
    output skts_pkg::res_t                  res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] TWO_C = CW'(2);

    skts_pkg::state_t            state_reg, state_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               idx_reg, idx_next;      // insert slot under test
    logic [CW-1:0]               lo_reg, lo_next;
    logic [CW-1:0]               hp1_reg, hp1_next;      // exclusive upper bound
    logic [AW-1:0]               mid_reg, mid_next;
    logic [skts_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [skts_pkg::PAY_W-1:0]  pay_reg, pay_next;
    skts_pkg::res_t              res_reg, res_next;

    logic                        accept;
    logic                        shift_up;
    logic                        span_open;
    logic [CW-1:0]               mid_full;
    logic [31:0]                 idx_ext;
    logic [31:0]                 mid_ext;

    assign accept    = req_valid && req_ready;
    assign shift_up  = ram_rdata.key > key_reg;
    assign span_open = lo_reg < hp1_reg;
    assign mid_full  = lo_reg + ((hp1_reg - ONE_C - lo_reg) >> 1);
    assign idx_ext   = 32'(idx_reg);
    assign mid_ext   = 32'(mid_reg);
    assign res       = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skts_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_action == skts_pkg::ACTION_LOOKUP)
                    begin
                        state_next = skts_pkg::S_LK_ADDR;
                    end
                    else if (count_reg == CAP_C)
                    begin
                        state_next = skts_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = skts_pkg::S_INS_ADDR;
                    end
                end
            end
            skts_pkg::S_INS_ADDR:
            begin
                state_next = (idx_reg == '0) ? skts_pkg::S_DONE : skts_pkg::S_INS_CMP;
            end
            skts_pkg::S_INS_CMP:
            begin
                if (!shift_up)
                begin
                    state_next = skts_pkg::S_DONE;
                end
                else if (idx_reg == ONE_C)
                begin
                    state_next = skts_pkg::S_INS_ADDR;
                end
            end
            skts_pkg::S_LK_ADDR:
            begin
                state_next = span_open ? skts_pkg::S_LK_CMP : skts_pkg::S_DONE;
            end
            skts_pkg::S_LK_CMP:
            begin
                state_next = (ram_rdata.key == key_reg) ? skts_pkg::S_DONE
                                                        : skts_pkg::S_LK_ADDR;
            end
            skts_pkg::S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = skts_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = skts_pkg::S_IDLE;
            end
        endcase
    end

    // outputs: handshakes and RAM port
    always_comb
    begin
        req_ready = 1'b0;
        res_valid = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = '{key: key_reg, payload: pay_reg};
        ram_raddr = mid_full[AW-1:0];
        case (state_reg)
            skts_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
            end
            skts_pkg::S_INS_ADDR:
            begin
                // empty slot reached the bottom: place the new record there
                ram_we    = (idx_reg == '0);
                ram_raddr = AW'(idx_reg - ONE_C);
            end
            skts_pkg::S_INS_CMP:
            begin
                ram_we    = 1'b1;
                ram_raddr = AW'(idx_reg - TWO_C);
                if (shift_up)
                begin
                    ram_wdata = ram_rdata;
                end
            end
            skts_pkg::S_LK_ADDR:
            begin
                ram_raddr = mid_full[AW-1:0];
            end
            skts_pkg::S_LK_CMP:
            begin
                ram_raddr = mid_full[AW-1:0];
            end
            skts_pkg::S_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        lo_next    = lo_reg;
        hp1_next   = hp1_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        pay_next   = pay_reg;
        res_next   = res_reg;
        case (state_reg)
            skts_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    key_next = req_key;
                    pay_next = req_payload;
                    idx_next = count_reg;
                    lo_next  = '0;
                    hp1_next = count_reg;
                    res_next = '{status: skts_pkg::ST_FULL, index: '0, found_payload: '0};
                end
            end
            skts_pkg::S_INS_ADDR:
            begin
                if (idx_reg == '0)
                begin
                    count_next = count_reg + ONE_C;
                    res_next   = '{status: skts_pkg::ST_INSERTED, index: '0,
                                   found_payload: '0};
                end
            end
            skts_pkg::S_INS_CMP:
            begin
                if (shift_up)
                begin
                    idx_next = idx_reg - ONE_C;
                end
                else
                begin
                    count_next = count_reg + ONE_C;
                    res_next   = '{status: skts_pkg::ST_INSERTED,
                                   index: idx_ext[skts_pkg::IDX_W-1:0],
                                   found_payload: '0};
                end
            end
            skts_pkg::S_LK_ADDR:
            begin
                mid_next = mid_full[AW-1:0];
                if (!span_open)
                begin
                    res_next = '{status: skts_pkg::ST_MISSING, index: '0, found_payload: '0};
                end
            end
            skts_pkg::S_LK_CMP:
            begin
                if (ram_rdata.key == key_reg)
                begin
                    res_next = '{status: skts_pkg::ST_FOUND,
                                 index: mid_ext[skts_pkg::IDX_W-1:0],
                                 found_payload: ram_rdata.payload};
                end
                else if (ram_rdata.key < key_reg)
                begin
                    lo_next = CW'(mid_reg) + ONE_C;
                end
                else
                begin
                    hp1_next = CW'(mid_reg);
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skts_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        lo_reg  <= lo_next;
        hp1_reg <= hp1_next;
        mid_reg <= mid_next;
        key_reg <= key_next;
        pay_reg <= pay_next;
        res_reg <= res_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + ONE_C))
        else $error("entry count moved by other than one");

    a_write_insert_only: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == skts_pkg::S_INS_ADDR || state_reg == skts_pkg::S_INS_CMP))
        else $error("table written outside an insert");

    a_insert_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (idx_reg < CAP_C && idx_reg <= count_reg))
        else $error("insert slot out of range");

endmodule
